// ----- rtl/core/rv32d_pkg.sv -----
// Shared codes, tables and result type for the RV32I instruction decoder.
package rv32d_pkg;

    // Major opcodes (word bits 6:0)
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    // funct3 codes that need special handling
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_JALR    = 3'd0;

    // Operation codes
    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_SUB     = 6'd1;
    localparam logic [5:0] OP_SLL     = 6'd2;
    localparam logic [5:0] OP_SLT     = 6'd3;
    localparam logic [5:0] OP_SLTU    = 6'd4;
    localparam logic [5:0] OP_XOR     = 6'd5;
    localparam logic [5:0] OP_SRL     = 6'd6;
    localparam logic [5:0] OP_SRA     = 6'd7;
    localparam logic [5:0] OP_OR      = 6'd8;
    localparam logic [5:0] OP_AND     = 6'd9;
    localparam logic [5:0] OP_ADDI    = 6'd10;
    localparam logic [5:0] OP_SLTI    = 6'd11;
    localparam logic [5:0] OP_SLTIU   = 6'd12;
    localparam logic [5:0] OP_XORI    = 6'd13;
    localparam logic [5:0] OP_ORI     = 6'd14;
    localparam logic [5:0] OP_ANDI    = 6'd15;
    localparam logic [5:0] OP_SLLI    = 6'd16;
    localparam logic [5:0] OP_SRLI    = 6'd17;
    localparam logic [5:0] OP_SRAI    = 6'd18;
    localparam logic [5:0] OP_LUI     = 6'd19;
    localparam logic [5:0] OP_AUIPC   = 6'd20;
    localparam logic [5:0] OP_LB      = 6'd21;
    localparam logic [5:0] OP_LH      = 6'd22;
    localparam logic [5:0] OP_LW      = 6'd23;
    localparam logic [5:0] OP_LBU     = 6'd24;
    localparam logic [5:0] OP_LHU     = 6'd25;
    localparam logic [5:0] OP_SB      = 6'd26;
    localparam logic [5:0] OP_SH      = 6'd27;
    localparam logic [5:0] OP_SW      = 6'd28;
    localparam logic [5:0] OP_BEQ     = 6'd29;
    localparam logic [5:0] OP_BNE     = 6'd30;
    localparam logic [5:0] OP_BLT     = 6'd31;
    localparam logic [5:0] OP_BGE     = 6'd32;
    localparam logic [5:0] OP_BLTU    = 6'd33;
    localparam logic [5:0] OP_BGEU    = 6'd34;
    localparam logic [5:0] OP_JAL     = 6'd35;
    localparam logic [5:0] OP_JALR    = 6'd36;
    localparam logic [5:0] OP_INVALID = 6'd37;

    // Format classes
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;
    localparam logic [2:0] FMT_X = 3'd6;

    // Operation by funct3, per opcode group
    localparam logic [5:0] R_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                         OP_XOR, OP_SRL, OP_OR, OP_AND};
    localparam logic [5:0] OPIMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
                                             OP_XORI, OP_SRLI, OP_ORI, OP_ANDI};
    localparam logic [5:0] LOAD_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_INVALID,
                                            OP_LBU, OP_LHU, OP_INVALID, OP_INVALID};
    localparam logic [5:0] STORE_OPS [8] = '{OP_SB, OP_SH, OP_SW, OP_INVALID,
                                             OP_INVALID, OP_INVALID, OP_INVALID,
                                             OP_INVALID};
    localparam logic [5:0] BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_INVALID, OP_INVALID,
                                              OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

    // One decoded instruction
    typedef struct packed {
        logic [5:0]         op_kind;
        logic [2:0]         format_class;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic signed [31:0] immediate;
        logic               branch_flag;
        logic               jump_flag;
        logic               load_flag;
        logic               store_flag;
    } decode_result_t;

endpackage

// ----- rtl/core/rv32d_decode.sv -----
// Combinational RV32I field decode: operation, format, registers, immediate, flags.
module rv32d_decode
(
    input  logic [31:0]                word,
    output rv32d_pkg::decode_result_t  result
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic        f7nz;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] shamt;
    logic [5:0]  op;
    logic [2:0]  fmt;
    logic [31:0] imm;
    logic        br;
    logic        jmp;
    logic        ld;
    logic        st;

    // Field slices and immediates for every format
    assign opc   = word[6:0];
    assign f3    = word[14:12];
    assign f7nz  = |word[31:25];
    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {word[31:12], 12'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign shamt = {27'b0, word[24:20]};

    // Opcode decode
    always_comb
    begin
        op  = rv32d_pkg::OP_INVALID;
        fmt = rv32d_pkg::FMT_X;
        imm = 32'b0;
        br  = 1'b0;
        jmp = 1'b0;
        ld  = 1'b0;
        st  = 1'b0;
        unique case (opc)
            rv32d_pkg::OPC_OP:
            begin
                fmt = rv32d_pkg::FMT_R;
                op  = rv32d_pkg::R_OPS[f3];
                // any nonzero funct7 picks SUB / SRA
                if (f7nz && (f3 == rv32d_pkg::F3_ADD_SUB || f3 == rv32d_pkg::F3_SRL_SRA))
                begin
                    op = rv32d_pkg::R_OPS[f3] + 6'd1;
                end
            end
            rv32d_pkg::OPC_LOAD:
            begin
                fmt = rv32d_pkg::FMT_I;
                ld  = 1'b1;
                op  = rv32d_pkg::LOAD_OPS[f3];
                imm = imm_i;
            end
            rv32d_pkg::OPC_JALR:
            begin
                fmt = rv32d_pkg::FMT_I;
                if (f3 == rv32d_pkg::F3_JALR)
                begin
                    op  = rv32d_pkg::OP_JALR;
                    jmp = 1'b1;
                    imm = imm_i;
                end
            end
            rv32d_pkg::OPC_OPIMM:
            begin
                fmt = rv32d_pkg::FMT_I;
                op  = rv32d_pkg::OPIMM_OPS[f3];
                imm = imm_i;
                // shifts carry shamt only
                if (f3 == rv32d_pkg::F3_SLL || f3 == rv32d_pkg::F3_SRL_SRA)
                begin
                    imm = shamt;
                    if (f3 == rv32d_pkg::F3_SRL_SRA && f7nz)
                    begin
                        op = rv32d_pkg::OP_SRAI;
                    end
                end
            end
            rv32d_pkg::OPC_STORE:
            begin
                fmt = rv32d_pkg::FMT_S;
                st  = 1'b1;
                op  = rv32d_pkg::STORE_OPS[f3];
                imm = imm_s;
            end
            rv32d_pkg::OPC_BRANCH:
            begin
                fmt = rv32d_pkg::FMT_B;
                br  = 1'b1;
                op  = rv32d_pkg::BRANCH_OPS[f3];
                imm = imm_b;
            end
            rv32d_pkg::OPC_LUI:
            begin
                fmt = rv32d_pkg::FMT_U;
                op  = rv32d_pkg::OP_LUI;
                imm = imm_u;
            end
            rv32d_pkg::OPC_AUIPC:
            begin
                fmt = rv32d_pkg::FMT_U;
                op  = rv32d_pkg::OP_AUIPC;
                imm = imm_u;
            end
            rv32d_pkg::OPC_JAL:
            begin
                fmt = rv32d_pkg::FMT_J;
                op  = rv32d_pkg::OP_JAL;
                jmp = 1'b1;
                imm = imm_j;
            end
            default:
            begin
                op = rv32d_pkg::OP_INVALID;
            end
        endcase
    end

    // Pack the result; an invalid operation never carries an immediate
    always_comb
    begin
        result.op_kind      = op;
        result.format_class = fmt;
        result.dest_reg     = word[11:7];
        result.src_reg_a    = word[19:15];
        result.src_reg_b    = word[24:20];
        result.immediate    = (op == rv32d_pkg::OP_INVALID) ? 32'sd0 : $signed(imm);
        result.branch_flag  = br;
        result.jump_flag    = jmp;
        result.load_flag    = ld;
        result.store_flag   = st;
    end

endmodule

// ----- rtl/core/rv32i_instruction_decoder_top.sv -----
// Top level of the RV32I instruction decoder: input register, decode, result register.
//
// Decodes one 32-bit RV32I instruction word per beat into operation code, format class,
// register fields, sign-extended immediate and branch/jump/load/store flags. The block
// holds no architectural state. Throughput is one instruction per clock while out_stall is
// low; the path is an input register stage, the field decode and a result register
// stage, in that order. Both channels use valid/stall; in_stall is high exactly while
// both stages are full and the result side is stalled, so after the result side stalls
// the input takes at most one more beat before it stalls too.
module rv32i_instruction_decoder_top
(
    input  logic               clk,
    input  logic               rst_n,
    // instruction channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instr_word,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         op_kind,
    output logic [2:0]         format_class,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src_reg_a,
    output logic [4:0]         src_reg_b,
    output logic signed [31:0] immediate,
    output logic               branch_flag,
    output logic               jump_flag,
    output logic               load_flag,
    output logic               store_flag
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [31:0]               instr_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    rv32d_pkg::decode_result_t res_reg;
    rv32d_pkg::decode_result_t dec_result;
    logic                      out_load;
    logic                      in_load;

    // Stage handshake: result stage loads when empty or drained,
    // input stage loads when empty or moving on
    assign out_load       = !out_valid_reg || !out_stall;
    assign in_load        = !in_valid_reg || out_load;
    assign in_stall       = !in_load;
    assign in_valid_next  = in_load ? in_valid : 1'b1;
    assign out_valid_next = out_load ? in_valid_reg : 1'b1;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            instr_reg <= instr_word;
        end
    end

    // Field decode
    rv32d_decode u_decode
    (
        .word   (instr_reg),
        .result (dec_result)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            res_reg <= dec_result;
        end
    end

    // Outputs
    assign out_valid    = out_valid_reg;
    assign op_kind      = res_reg.op_kind;
    assign format_class = res_reg.format_class;
    assign dest_reg     = res_reg.dest_reg;
    assign src_reg_a    = res_reg.src_reg_a;
    assign src_reg_b    = res_reg.src_reg_b;
    assign immediate    = res_reg.immediate;
    assign branch_flag  = res_reg.branch_flag;
    assign jump_flag    = res_reg.jump_flag;
    assign load_flag    = res_reg.load_flag;
    assign store_flag   = res_reg.store_flag;

endmodule

// ----- rtl/core/rv32d_checker.sv -----
// Port-level checks for the RV32I instruction decoder, bound to the top level.
module rv32d_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [5:0]         op_kind,
    input logic [2:0]         format_class,
    input logic signed [31:0] immediate,
    input logic               branch_flag,
    input logic               jump_flag,
    input logic               load_flag,
    input logic               store_flag
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(op_kind) && $stable(immediate))
        else $error("stalled result beat changed");

    // Input stalls only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without back-pressure");

    // Invalid operations carry no immediate and no jump
    a_invalid_imm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_kind == rv32d_pkg::OP_INVALID |-> immediate == 32'sd0 && !jump_flag)
        else $error("invalid op with immediate or jump");

    // At most one class flag per instruction
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({branch_flag, jump_flag, load_flag, store_flag}))
        else $error("more than one class flag set");

    // Load flag implies I format
    a_load_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_flag |-> format_class == rv32d_pkg::FMT_I)
        else $error("load without I format");

endmodule

bind rv32i_instruction_decoder_top rv32d_checker u_rv32d_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .op_kind      (op_kind),
    .format_class (format_class),
    .immediate    (immediate),
    .branch_flag  (branch_flag),
    .jump_flag    (jump_flag),
    .load_flag    (load_flag),
    .store_flag   (store_flag)
);

// ----- tb/sv/rv32i_instruction_decoder_top_tb.sv -----
// Self-checking testbench for the RV32I instruction decoder top level.
`timescale 1ns / 100ps

module rv32i_instruction_decoder_top_tb;

    // Cycles without any beat before the run is abandoned
    localparam int IDLE_LIMIT   = 1000;
    // Cycles to let the pipeline drain once nothing is outstanding
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 540;

    localparam logic [6:0] KNOWN_OPCODES [9] = '{rv32d_pkg::OPC_OP, rv32d_pkg::OPC_LOAD,
                                                 rv32d_pkg::OPC_JALR, rv32d_pkg::OPC_OPIMM,
                                                 rv32d_pkg::OPC_STORE, rv32d_pkg::OPC_BRANCH,
                                                 rv32d_pkg::OPC_LUI, rv32d_pkg::OPC_AUIPC,
                                                 rv32d_pkg::OPC_JAL};
    localparam logic [6:0] UNDEF_OPCODES [8] = '{7'h00, 7'h7F, 7'h0B, 7'h0F,
                                                 7'h73, 7'h2F, 7'h53, 7'h3B};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        instr_word;
    logic               out_valid;
    logic               out_stall;
    logic [5:0]         op_kind;
    logic [2:0]         format_class;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic               branch_flag;
    logic               jump_flag;
    logic               load_flag;
    logic               store_flag;

    rv32d_pkg::decode_result_t pending_decodes [$];
    int             mismatch_count = 0;
    int             idle_cycles    = 0;
    int             burst_left     = 0;
    bit             gaps_enabled   = 1'b1;
    int             hold_off_cycles = 0;

    rv32i_instruction_decoder_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instr_word   (instr_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .op_kind      (op_kind),
        .format_class (format_class),
        .dest_reg     (dest_reg),
        .src_reg_a    (src_reg_a),
        .src_reg_b    (src_reg_b),
        .immediate    (immediate),
        .branch_flag  (branch_flag),
        .jump_flag    (jump_flag),
        .load_flag    (load_flag),
        .store_flag   (store_flag)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Expected decode of one instruction word
    function automatic rv32d_pkg::decode_result_t decode_instruction(input logic [31:0] w);
        rv32d_pkg::decode_result_t res;
        logic [6:0]        opc;
        logic [2:0]        f3;
        logic              f7_set;
        logic [31:0]       imm_i;
        logic [31:0]       imm_s;
        logic [31:0]       imm_b;
        logic [31:0]       imm_j;
        logic [31:0]       shamt;
        opc    = w[6:0];
        f3     = w[14:12];
        f7_set = |w[31:25];
        imm_i  = {{20{w[31]}}, w[31:20]};
        imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        shamt  = {27'd0, w[24:20]};

        res              = '0;
        res.op_kind      = rv32d_pkg::OP_INVALID;
        res.format_class = rv32d_pkg::FMT_X;
        res.dest_reg     = w[11:7];
        res.src_reg_a    = w[19:15];
        res.src_reg_b    = w[24:20];

        case (opc)
            rv32d_pkg::OPC_OP:
            begin
                res.format_class = rv32d_pkg::FMT_R;
                case (f3)
                    3'd0: res.op_kind = f7_set ? rv32d_pkg::OP_SUB : rv32d_pkg::OP_ADD;
                    3'd1: res.op_kind = rv32d_pkg::OP_SLL;
                    3'd2: res.op_kind = rv32d_pkg::OP_SLT;
                    3'd3: res.op_kind = rv32d_pkg::OP_SLTU;
                    3'd4: res.op_kind = rv32d_pkg::OP_XOR;
                    3'd5: res.op_kind = f7_set ? rv32d_pkg::OP_SRA : rv32d_pkg::OP_SRL;
                    3'd6: res.op_kind = rv32d_pkg::OP_OR;
                    default: res.op_kind = rv32d_pkg::OP_AND;
                endcase
            end
            rv32d_pkg::OPC_LOAD:
            begin
                res.format_class = rv32d_pkg::FMT_I;
                res.load_flag    = 1'b1;
                res.immediate    = imm_i;
                case (f3)
                    3'd0: res.op_kind = rv32d_pkg::OP_LB;
                    3'd1: res.op_kind = rv32d_pkg::OP_LH;
                    3'd2: res.op_kind = rv32d_pkg::OP_LW;
                    3'd4: res.op_kind = rv32d_pkg::OP_LBU;
                    3'd5: res.op_kind = rv32d_pkg::OP_LHU;
                    default: res.op_kind = rv32d_pkg::OP_INVALID;
                endcase
            end
            rv32d_pkg::OPC_JALR:
            begin
                res.format_class = rv32d_pkg::FMT_I;
                if (f3 == rv32d_pkg::F3_JALR)
                begin
                    res.op_kind   = rv32d_pkg::OP_JALR;
                    res.jump_flag = 1'b1;
                    res.immediate = imm_i;
                end
            end
            rv32d_pkg::OPC_OPIMM:
            begin
                res.format_class = rv32d_pkg::FMT_I;
                res.immediate    = imm_i;
                case (f3)
                    3'd0: res.op_kind = rv32d_pkg::OP_ADDI;
                    3'd1:
                    begin
                        res.op_kind   = rv32d_pkg::OP_SLLI;
                        res.immediate = shamt;
                    end
                    3'd2: res.op_kind = rv32d_pkg::OP_SLTI;
                    3'd3: res.op_kind = rv32d_pkg::OP_SLTIU;
                    3'd4: res.op_kind = rv32d_pkg::OP_XORI;
                    3'd5:
                    begin
                        res.op_kind   = f7_set ? rv32d_pkg::OP_SRAI : rv32d_pkg::OP_SRLI;
                        res.immediate = shamt;
                    end
                    3'd6: res.op_kind = rv32d_pkg::OP_ORI;
                    default: res.op_kind = rv32d_pkg::OP_ANDI;
                endcase
            end
            rv32d_pkg::OPC_STORE:
            begin
                res.format_class = rv32d_pkg::FMT_S;
                res.store_flag   = 1'b1;
                res.immediate    = imm_s;
                case (f3)
                    3'd0: res.op_kind = rv32d_pkg::OP_SB;
                    3'd1: res.op_kind = rv32d_pkg::OP_SH;
                    3'd2: res.op_kind = rv32d_pkg::OP_SW;
                    default: res.op_kind = rv32d_pkg::OP_INVALID;
                endcase
            end
            rv32d_pkg::OPC_BRANCH:
            begin
                res.format_class = rv32d_pkg::FMT_B;
                res.branch_flag  = 1'b1;
                res.immediate    = imm_b;
                case (f3)
                    3'd0: res.op_kind = rv32d_pkg::OP_BEQ;
                    3'd1: res.op_kind = rv32d_pkg::OP_BNE;
                    3'd4: res.op_kind = rv32d_pkg::OP_BLT;
                    3'd5: res.op_kind = rv32d_pkg::OP_BGE;
                    3'd6: res.op_kind = rv32d_pkg::OP_BLTU;
                    3'd7: res.op_kind = rv32d_pkg::OP_BGEU;
                    default: res.op_kind = rv32d_pkg::OP_INVALID;
                endcase
            end
            rv32d_pkg::OPC_LUI:
            begin
                res.format_class = rv32d_pkg::FMT_U;
                res.op_kind      = rv32d_pkg::OP_LUI;
                res.immediate    = {w[31:12], 12'd0};
            end
            rv32d_pkg::OPC_AUIPC:
            begin
                res.format_class = rv32d_pkg::FMT_U;
                res.op_kind      = rv32d_pkg::OP_AUIPC;
                res.immediate    = {w[31:12], 12'd0};
            end
            rv32d_pkg::OPC_JAL:
            begin
                res.format_class = rv32d_pkg::FMT_J;
                res.op_kind      = rv32d_pkg::OP_JAL;
                res.jump_flag    = 1'b1;
                res.immediate    = imm_j;
            end
            default:
            begin
            end
        endcase

        // undefined encodings never carry an immediate
        if (res.op_kind == rv32d_pkg::OP_INVALID)
            res.immediate = '0;
        return res;
    endfunction

    function automatic logic [31:0] make_word(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // Random register index
    function automatic logic [4:0] rand_reg();
        return 5'($urandom_range(0, 31));
    endfunction

    // Random funct7 from the given lower bound up to 127
    function automatic logic [6:0] rand_f7(input int lo);
        return 7'($urandom_range(lo, 127));
    endfunction

    // Mostly well-formed words with random fields, some pure noise
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 6) != 0)
        begin
            w[6:0] = KNOWN_OPCODES[$urandom_range(0, 8)];
            if ($urandom_range(0, 2) == 0)
                w[31:25] = 7'h00;
        end
        return w;
    endfunction

    // Offer one word, wait for the beat, then maybe open a gap
    task automatic send_instruction(input logic [31:0] word);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        instr_word <= word;
        do
            @(posedge clk);
        while (in_stall);
        pending_decodes.push_back(decode_instruction(word));

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && gaps_enabled)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic field_check(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rv32d_pkg::decode_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result beat with no instruction outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                field_check("op_kind",      32'(want.op_kind),      32'(op_kind));
                field_check("format_class", 32'(want.format_class), 32'(format_class));
                field_check("dest_reg",     32'(want.dest_reg),     32'(dest_reg));
                field_check("src_reg_a",    32'(want.src_reg_a),    32'(src_reg_a));
                field_check("src_reg_b",    32'(want.src_reg_b),    32'(src_reg_b));
                field_check("immediate",    want.immediate,         immediate);
                field_check("branch_flag",  32'(want.branch_flag),  32'(branch_flag));
                field_check("jump_flag",    32'(want.jump_flag),    32'(jump_flag));
                field_check("load_flag",    32'(want.load_flag),    32'(load_flag));
                field_check("store_flag",   32'(want.store_flag),   32'(store_flag));
            end
        end
    end

    // Watchdog: no beat on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("rv32i_instruction_decoder_top: mismatch");
                $finish;
            end
        end
    end

    // Result side stall: segments of no, light and heavy stalling, plus long hold-offs
    initial
    begin
        int hold;
        int seg_left;
        int mode;
        seg_left  = 0;
        mode      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold            = hold_off_cycles;
                hold_off_cycles = 0;
                out_stall <= 1'b1;
                repeat (hold - 1)
                    @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 80);
                end
                seg_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    // Register-register ops, both funct7 settings for every funct3
    task automatic test_register_ops();
        for (int f3 = 0; f3 < 8; f3++)
        begin
            send_instruction(make_word(7'h00, rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_OP));
            send_instruction(make_word(rand_f7(1), rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_OP));
        end
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, rv32d_pkg::F3_ADD_SUB, 5'd31,
                                   rv32d_pkg::OPC_OP));
        send_instruction(make_word(7'h00, 5'd0, 5'd0, rv32d_pkg::F3_ADD_SUB, 5'd0,
                                   rv32d_pkg::OPC_OP));
    endtask

    // Immediate ALU ops, shift amounts, immediate extremes, upper-immediate ops
    task automatic test_immediate_ops();
        for (int f3 = 0; f3 < 8; f3++)
            send_instruction(make_word(7'h00, rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h20, 5'd31, 5'd3, rv32d_pkg::F3_SRL_SRA, 5'd7,
                                   rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h01, 5'd17, 5'd3, rv32d_pkg::F3_SRL_SRA, 5'd7,
                                   rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h7F, 5'd31, 5'd9, rv32d_pkg::F3_SLL, 5'd1,
                                   rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h3F, 5'd31, 5'd0, 3'd0, 5'd1, rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h40, 5'd0, 5'd31, 3'd0, 5'd31, rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, rv32d_pkg::OPC_OPIMM));
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, rv32d_pkg::OPC_LUI));
        send_instruction(make_word(7'h00, 5'd0, 5'd0, 3'd0, 5'd0, rv32d_pkg::OPC_LUI));
        send_instruction(make_word(7'h40, 5'd0, 5'd0, 3'd0, 5'd5, rv32d_pkg::OPC_AUIPC));
    endtask

    // Loads and stores over every funct3, including the undefined ones
    task automatic test_memory_ops();
        for (int f3 = 0; f3 < 8; f3++)
        begin
            send_instruction(make_word(rand_f7(0), rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_LOAD));
            send_instruction(make_word(rand_f7(0), rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_STORE));
        end
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, rv32d_pkg::OPC_STORE));
        send_instruction(make_word(7'h40, 5'd0, 5'd0, 3'd0, 5'd0, rv32d_pkg::OPC_STORE));
    endtask

    // Branches, JAL and JALR, with immediate extremes and undefined funct3
    task automatic test_control_ops();
        for (int f3 = 0; f3 < 8; f3++)
        begin
            send_instruction(make_word(rand_f7(0), rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_BRANCH));
            send_instruction(make_word(rand_f7(0), rand_reg(), rand_reg(), 3'(f3), rand_reg(),
                                       rv32d_pkg::OPC_JALR));
        end
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, rv32d_pkg::OPC_BRANCH));
        send_instruction(make_word(7'h3F, 5'd31, 5'd31, 3'd0, 5'd31, rv32d_pkg::OPC_BRANCH));
        send_instruction(make_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, rv32d_pkg::OPC_JAL));
        send_instruction(make_word(7'h3F, 5'd31, 5'd31, 3'd7, 5'd31, rv32d_pkg::OPC_JAL));
    endtask

    // Opcodes outside the nine the decoder handles decode as invalid
    task automatic test_undefined_opcodes();
        logic [31:0] w;
        send_instruction(32'h0000_0000);
        send_instruction(32'hFFFF_FFFF);
        foreach (UNDEF_OPCODES[i])
        begin
            w      = $urandom();
            w[6:0] = UNDEF_OPCODES[i];
            send_instruction(w);
        end
    endtask

    // Long result-side hold-off while words keep coming, to fill the pipe
    task automatic test_backpressure();
        gaps_enabled    = 1'b0;
        hold_off_cycles = 64;
        repeat (24)
            send_instruction(random_instruction());
        gaps_enabled = 1'b1;
        burst_left   = 0;
    endtask

    task automatic test_random_words();
        repeat (RANDOM_ITEMS)
            send_instruction(random_instruction());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        instr_word = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_ops();
        test_immediate_ops();
        test_memory_ops();
        test_control_ops();
        test_undefined_opcodes();
        test_backpressure();
        test_random_words();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("rv32i_instruction_decoder_top: match");
        else
            $display("rv32i_instruction_decoder_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rv32d_pkg.sv
rtl/core/rv32d_decode.sv
rtl/core/rv32i_instruction_decoder_top.sv
rtl/core/rv32d_checker.sv
tb/sv/rv32i_instruction_decoder_top_tb.sv
